// ===== design/soda_pkg.sv =====
// Shared constants, codes and stage structures for the second-order dual arithmetic unit.
// Depends on nothing; every other design file but soda_if refers to it by scoped names.
package soda_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int LANES     = 3;
  // Largest dividend magnitude (second-derivative numerator) and divisor magnitude (|g|^3).
  localparam int NUM_W     = 97;
  localparam int DEN_W     = 94;
  // Remainder width: holds divisor << Q_W and dividend << FRAC_BITS.
  localparam int DIV_W     = DEN_W + Q_W;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // One result field on its way to the divider: either a finished magnitude
  // (q, ovf) or a dividend/divisor pair (div set).
  typedef struct packed {
    logic             div;
    logic             neg;
    logic             ovf;
    logic [Q_W-1:0]   q;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lane_t;

  typedef struct packed {
    logic                  vld;
    logic                  dz;
    lane_t [LANES-1:0]     lane;
  } item_t;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [Q_W-1:0] q;
  } qlane_t;

  typedef struct packed {
    logic                  vld;
    logic                  dz;
    qlane_t [LANES-1:0]    lane;
  } quot_t;

endpackage

// ===== design/soda_if.sv =====
// Channel interfaces: operand transactions in, result transactions out.
// Depends on nothing; valid/ready handshake with the payload alongside.
interface soda_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] a_value;
  logic signed [31:0] a_first;
  logic signed [31:0] a_second;
  logic signed [31:0] b_value;
  logic signed [31:0] b_first;
  logic signed [31:0] b_second;

  modport source (output valid, action, a_value, a_first, a_second, b_value, b_first,
                  b_second, input ready);
  modport sink   (input valid, action, a_value, a_first, a_second, b_value, b_first,
                  b_second, output ready);
endinterface

interface soda_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_value;
  logic signed [31:0] res_first;
  logic signed [31:0] res_second;
  logic [1:0]         status;

  modport source (output valid, res_value, res_first, res_second, status, input ready);
  modport sink   (input valid, res_value, res_first, res_second, status, output ready);
endinterface

// ===== design/second_order_dual_arithmetic_unit.sv =====
// Top level of the second-order dual arithmetic unit.
// Depends on soda_pkg, soda_if, soda_front, soda_div and soda_back.
//
// Usage:
//   req carries one operand transaction: action (add, subtract, multiply,
//   divide) and operands a and b, each as value, first and second directional
//   derivative in signed Q16.16. rsp returns one result transaction per
//   request, in order: three saturated Q16.16 fields and a status code
//   (ok, saturated, divide by zero).
//   Throughput: one transaction per cycle for any action mix, sustained while
//   rsp.ready stays high. Seven front stages form the products and rule sums,
//   33 divider stages follow (an overflow check and one restoring quotient bit
//   per stage for 32 bits), and the output register comes last.
//   Reset (rst, synchronous) clears every valid bit; no result is pending
//   afterwards and req.ready is high.
//   Stall: when rsp.ready is low the output register holds its transaction
//   and one more lands in the skid entry; req.ready then falls and the whole
//   pipeline freezes until the skid entry drains. Nothing is dropped or
//   repeated, and req.ready depends only on registered state.
module second_order_dual_arithmetic_unit (
  input logic         clk,
  input logic         rst,
  soda_in_if.sink     req,
  soda_out_if.source  rsp
);

  // Advance enable for every pipeline stage; low only while the skid entry is full.
  logic            en;
  // Prepared lanes: finished magnitudes or dividend/divisor pairs.
  soda_pkg::item_t item;
  // Quotients and pass-through magnitudes, ready for saturation.
  soda_pkg::quot_t quot;

  soda_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .req  (req),
    .dout (item)
  );

  soda_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (item),
    .dout (quot)
  );

  soda_back u_back (
    .clk (clk),
    .rst (rst),
    .din (quot),
    .en  (en),
    .rsp (rsp)
  );

endmodule

// ===== design/soda_front.sv =====
// Front pipeline: products, product/quotient rule sums and dividend/divisor preparation.
// Depends on soda_pkg and soda_in_if; seven register stages, all advanced by en.
module soda_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  soda_in_if.sink         req,
  output soda_pkg::item_t dout
);

  localparam int F = soda_pkg::FRAC_BITS;
  localparam int Q = soda_pkg::Q_W;

  // stage 1: captured operands
  logic               s1_v;
  logic [1:0]         s1_act;
  logic signed [31:0] s1_f, s1_f1, s1_f2, s1_g, s1_g1, s1_g2;

  // stage 2: single products and element sums
  logic               s2_v, s2_dz;
  logic [1:0]         s2_act;
  logic signed [31:0] s2_f, s2_g, s2_g1;
  logic signed [63:0] s2_fg, s2_f1g, s2_fg1, s2_f2g, s2_f1g1, s2_fg2, s2_gg;
  logic signed [32:0] s2_s0, s2_s1, s2_s2;

  // stage 3: rule sums
  logic               s3_v, s3_dz;
  logic [1:0]         s3_act;
  logic signed [31:0] s3_f, s3_g, s3_g1;
  logic signed [32:0] s3_s0, s3_s1, s3_s2;
  logic signed [63:0] s3_m0, s3_gg;
  logic signed [65:0] s3_m1, s3_m2;
  logic signed [64:0] s3_d1, s3_d2;

  // stage 4: lanes prepared, partial products of the wide multiplies
  soda_pkg::item_t    s4_item, item4;
  logic signed [64:0] s4_tl, s4_th, s4_ul, s4_uh, s4_wl, s4_wh;

  // stage 5: wide products
  soda_pkg::item_t    s5_item;
  logic signed [97:0] s5_t, s5_dg, s5_g3;

  // stage 6: second-derivative dividend
  soda_pkg::item_t    s6_item, item7;
  logic signed [98:0] s6_n2;
  logic signed [97:0] s6_g3;

  logic signed [65:0] bv   [soda_pkg::LANES];
  logic [65:0]        bmag [soda_pkg::LANES];
  logic [65:0]        bsh  [soda_pkg::LANES];
  logic [31:0]        fmag, gmag;
  logic [64:0]        d1mag;
  logic [98:0]        n2mag;
  logic [97:0]        g3mag;

  assign req.ready = en;

  // Select per-field magnitudes; a divide loads dividend and divisor instead.
  always_comb begin
    bv[0] = (s3_act == soda_pkg::ACT_MUL) ? 66'(s3_m0) : 66'(s3_s0);
    bv[1] = (s3_act == soda_pkg::ACT_MUL) ? s3_m1 : 66'(s3_s1);
    bv[2] = (s3_act == soda_pkg::ACT_MUL) ? s3_m2 : 66'(s3_s2);
    fmag  = s3_f[31] ? 32'(-s3_f) : 32'(s3_f);
    gmag  = s3_g[31] ? 32'(-s3_g) : 32'(s3_g);
    d1mag = s3_d1[64] ? 65'(-s3_d1) : 65'(s3_d1);
    item4.vld = s3_v;
    item4.dz  = s3_dz;
    for (int l = 0; l < soda_pkg::LANES; l++) begin
      bmag[l] = bv[l][65] ? 66'(-bv[l]) : 66'(bv[l]);
      bsh[l]  = (s3_act == soda_pkg::ACT_MUL) ? (bmag[l] >> F) : bmag[l];
      item4.lane[l].div = 1'b0;
      item4.lane[l].neg = bv[l][65];
      item4.lane[l].ovf = |bsh[l][65:Q];
      item4.lane[l].q   = bsh[l][Q-1:0];
      item4.lane[l].num = '0;
      item4.lane[l].den = '0;
    end
    if (s3_act == soda_pkg::ACT_DIV) begin
      for (int l = 0; l < soda_pkg::LANES; l++) begin
        item4.lane[l].div = ~s3_dz;
        item4.lane[l].neg = 1'b0;
        item4.lane[l].ovf = 1'b0;
        item4.lane[l].q   = '0;
      end
      if (!s3_dz) begin
        item4.lane[0].neg = s3_f[31] ^ s3_g[31];
        item4.lane[0].num = soda_pkg::NUM_W'(fmag);
        item4.lane[0].den = soda_pkg::DEN_W'(gmag);
        item4.lane[1].neg = s3_d1[64];
        item4.lane[1].num = soda_pkg::NUM_W'(d1mag);
        item4.lane[1].den = soda_pkg::DEN_W'(s3_gg);
      end
    end
  end

  // Fill in the second-derivative quotient operands.
  always_comb begin
    n2mag = s6_n2[98] ? 99'(-s6_n2) : 99'(s6_n2);
    g3mag = s6_g3[97] ? 98'(-s6_g3) : 98'(s6_g3);
    item7 = s6_item;
    if (s6_item.lane[2].div) begin
      item7.lane[2].neg = s6_n2[98] ^ s6_g3[97];
      item7.lane[2].num = soda_pkg::NUM_W'(n2mag);
      item7.lane[2].den = soda_pkg::DEN_W'(g3mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v   <= req.valid;
      s1_act <= req.action;
      s1_f   <= req.a_value;
      s1_f1  <= req.a_first;
      s1_f2  <= req.a_second;
      s1_g   <= req.b_value;
      s1_g1  <= req.b_first;
      s1_g2  <= req.b_second;

      s2_v    <= s1_v;
      s2_act  <= s1_act;
      s2_dz   <= (s1_act == soda_pkg::ACT_DIV) && (s1_g == 32'sd0);
      s2_f    <= s1_f;
      s2_g    <= s1_g;
      s2_g1   <= s1_g1;
      s2_fg   <= s1_f * s1_g;
      s2_f1g  <= s1_f1 * s1_g;
      s2_fg1  <= s1_f * s1_g1;
      s2_f2g  <= s1_f2 * s1_g;
      s2_f1g1 <= s1_f1 * s1_g1;
      s2_fg2  <= s1_f * s1_g2;
      s2_gg   <= s1_g * s1_g;
      s2_s0   <= (s1_act == soda_pkg::ACT_SUB) ? s1_f - s1_g : s1_f + s1_g;
      s2_s1   <= (s1_act == soda_pkg::ACT_SUB) ? s1_f1 - s1_g1 : s1_f1 + s1_g1;
      s2_s2   <= (s1_act == soda_pkg::ACT_SUB) ? s1_f2 - s1_g2 : s1_f2 + s1_g2;

      s3_v   <= s2_v;
      s3_act <= s2_act;
      s3_dz  <= s2_dz;
      s3_f   <= s2_f;
      s3_g   <= s2_g;
      s3_g1  <= s2_g1;
      s3_s0  <= s2_s0;
      s3_s1  <= s2_s1;
      s3_s2  <= s2_s2;
      s3_m0  <= s2_fg;
      s3_gg  <= s2_gg;
      s3_m1  <= s2_f1g + s2_fg1;
      s3_m2  <= s2_f2g + (s2_f1g1 <<< 1) + s2_fg2;
      s3_d1  <= s2_f1g - s2_fg1;
      s3_d2  <= s2_f2g - s2_fg2;

      // Split each wide factor into a signed upper and unsigned lower half.
      s4_item <= item4;
      s4_tl   <= $signed({1'b0, s3_d1[31:0]}) * s3_g1;
      s4_th   <= $signed(s3_d1[64:32]) * s3_g1;
      s4_ul   <= $signed({1'b0, s3_d2[31:0]}) * s3_g;
      s4_uh   <= $signed(s3_d2[64:32]) * s3_g;
      s4_wl   <= $signed({1'b0, s3_gg[31:0]}) * s3_g;
      s4_wh   <= $signed(s3_gg[63:32]) * s3_g;

      s5_item <= s4_item;
      s5_t    <= (s4_th <<< 32) + s4_tl;
      s5_dg   <= (s4_uh <<< 32) + s4_ul;
      s5_g3   <= (s4_wh <<< 32) + s4_wl;

      s6_item <= s5_item;
      s6_n2   <= s5_dg - (s5_t <<< 1);
      s6_g3   <= s5_g3;

      dout <= item7;
    end
    if (rst) begin
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      s3_v        <= 1'b0;
      s4_item.vld <= 1'b0;
      s5_item.vld <= 1'b0;
      s6_item.vld <= 1'b0;
      dout.vld    <= 1'b0;
    end
  end

endmodule

// ===== design/soda_div.sv =====
// Pipelined restoring divider, three lanes, one quotient bit per stage after an overflow check.
// Depends on soda_pkg; lanes without a division pass their magnitude straight through.
module soda_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  soda_pkg::item_t din,
  output soda_pkg::quot_t dout
);

  localparam int Q = soda_pkg::Q_W;
  localparam int W = soda_pkg::DIV_W;

  typedef struct packed {
    logic                      div;
    logic                      neg;
    logic                      ovf;
    logic [Q-1:0]              q;
    logic [W-1:0]              rem;
    logic [soda_pkg::DEN_W-1:0] den;
  } dlane_t;

  dlane_t     ln [0:Q][soda_pkg::LANES];
  logic [Q:0] vld;
  logic [Q:0] dz;

  always_ff @(posedge clk) begin
    if (en) begin
      vld <= {vld[Q-1:0], din.vld};
      dz  <= {dz[Q-1:0], din.dz};
    end
    if (rst) begin
      vld <= '0;
    end
  end

  genvar k, l;
  generate
    for (l = 0; l < soda_pkg::LANES; l++) begin : g_head
      logic [W-1:0] rem0;
      logic [W-1:0] lim;
      logic         big;
      assign rem0 = W'(din.lane[l].num) << soda_pkg::FRAC_BITS;
      assign lim  = {din.lane[l].den, {Q{1'b0}}};
      // A quotient of 2^32 or more saturates whatever its sign.
      assign big  = din.lane[l].div & (rem0 >= lim);
      always_ff @(posedge clk) begin
        if (en) begin
          ln[0][l].div <= din.lane[l].div & ~big;
          ln[0][l].neg <= din.lane[l].neg;
          ln[0][l].ovf <= din.lane[l].ovf | big;
          ln[0][l].q   <= din.lane[l].q;
          ln[0][l].rem <= rem0;
          ln[0][l].den <= din.lane[l].den;
        end
      end
    end

    for (k = 1; k <= Q; k++) begin : g_step
      for (l = 0; l < soda_pkg::LANES; l++) begin : g_lane
        logic [W-1:0] dsh;
        logic [W:0]   diff;
        logic         take;
        assign dsh  = W'(ln[k-1][l].den) << (Q - k);
        assign diff = {1'b0, ln[k-1][l].rem} - {1'b0, dsh};
        assign take = ln[k-1][l].div & ~diff[W];
        always_ff @(posedge clk) begin
          if (en) begin
            ln[k][l] <= ln[k-1][l];
            if (take) begin
              ln[k][l].rem     <= diff[W-1:0];
              ln[k][l].q[Q-k]  <= 1'b1;
            end
          end
        end
      end
    end
  endgenerate

  always_comb begin
    dout.vld = vld[Q];
    dout.dz  = dz[Q];
    for (int i = 0; i < soda_pkg::LANES; i++) begin
      dout.lane[i].neg = ln[Q][i].neg;
      dout.lane[i].ovf = ln[Q][i].ovf;
      dout.lane[i].q   = ln[Q][i].q;
    end
  end

endmodule

// ===== design/soda_back.sv =====
// Result stage: sign, saturation and status, then an output register with a skid entry.
// Depends on soda_pkg and soda_out_if; en tells the pipeline it may advance.
module soda_back (
  input  logic            clk,
  input  logic            rst,
  input  soda_pkg::quot_t din,
  output logic            en,
  soda_out_if.source      rsp
);

  typedef struct packed {
    logic signed [31:0] res_value;
    logic signed [31:0] res_first;
    logic signed [31:0] res_second;
    logic [1:0]         status;
  } res_t;

  logic [31:0]                val [soda_pkg::LANES];
  logic [soda_pkg::LANES-1:0] sat;
  res_t                       settled, obuf, sbuf;
  logic                       ov, sv, push;

  always_comb begin
    for (int l = 0; l < soda_pkg::LANES; l++) begin
      if (din.lane[l].neg) begin
        sat[l] = din.lane[l].ovf | (din.lane[l].q > 32'h8000_0000);
        val[l] = sat[l] ? 32'h8000_0000 : 32'(-din.lane[l].q);
      end else begin
        sat[l] = din.lane[l].ovf | din.lane[l].q[31];
        val[l] = sat[l] ? 32'h7FFF_FFFF : din.lane[l].q;
      end
    end
    settled.res_value  = $signed(val[0]);
    settled.res_first  = $signed(val[1]);
    settled.res_second = $signed(val[2]);
    if (din.dz) begin
      settled.status = soda_pkg::ST_DZ;
    end else if (|sat) begin
      settled.status = soda_pkg::ST_SAT;
    end else begin
      settled.status = soda_pkg::ST_OK;
    end
  end

  assign en   = ~sv;
  assign push = en & din.vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (rsp.ready) begin
        obuf <= sbuf;
        sv   <= 1'b0;
      end
    end else if (push) begin
      if (ov && !rsp.ready) begin
        sbuf <= settled;
        sv   <= 1'b1;
      end else begin
        obuf <= settled;
        ov   <= 1'b1;
      end
    end else if (ov && rsp.ready) begin
      ov <= 1'b0;
    end
  end

  assign rsp.valid      = ov;
  assign rsp.res_value  = obuf.res_value;
  assign rsp.res_first  = obuf.res_first;
  assign rsp.res_second = obuf.res_second;
  assign rsp.status     = obuf.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry holds a transaction while the output register is empty");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    sv && !rsp.ready |=> sv && $stable(sbuf))
    else $error("skid entry lost or changed while the receiver stalls");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    ov && obuf.status == soda_pkg::ST_DZ |->
      obuf.res_value == 32'sd0 && obuf.res_first == 32'sd0 && obuf.res_second == 32'sd0)
    else $error("divide by zero result carries non-zero fields");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the second-order dual arithmetic unit.
// Depends on soda_pkg, soda_if and the unit itself; predicts every result in exact arithmetic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 1130;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] a_value, a_first, a_second, b_value, b_first, b_second;
  } operands_t;

  typedef struct packed {
    logic signed [31:0] res_value, res_first, res_second;
    logic [1:0]         status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  soda_in_if  req();
  soda_out_if rsp();

  second_order_dual_arithmetic_unit u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #HALF_PERIOD clk = ~clk;

  operands_t pending_ops[$];
  outcome_t  expected_outcomes[$];
  int        mismatches = 0;
  int        src_idle_pct = 21;
  int        snk_idle_pct = 59;
  int        quiet_cycles = 0;
  bit        stim_done = 1'b0;
  // Set at the rising edge when the presented transaction was taken.
  bit        req_taken = 1'b0;

  // Clamp an exact value into a 32-bit field, noting any saturation.
  function automatic logic signed [31:0] clamp32(input logic signed [255:0] x, inout bit sat);
    if (x > 256'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (x < -256'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Quotient truncated toward zero; the operator already truncates that way.
  function automatic logic signed [255:0] tdiv(input logic signed [255:0] n,
                                               input logic signed [255:0] d);
    return n / d;
  endfunction

  function automatic outcome_t dual_arith(input operands_t op);
    logic signed [255:0] f, f1, f2, g, g1, g2, rv, r1, r2, d1, d2, gsq, gcb;
    outcome_t o;
    bit sat;
    f = op.a_value; f1 = op.a_first; f2 = op.a_second;
    g = op.b_value; g1 = op.b_first; g2 = op.b_second;
    sat = 1'b0;
    o = '0;
    case (op.action)
      soda_pkg::ACT_ADD: begin
        rv = f + g; r1 = f1 + g1; r2 = f2 + g2;
      end
      soda_pkg::ACT_SUB: begin
        rv = f - g; r1 = f1 - g1; r2 = f2 - g2;
      end
      soda_pkg::ACT_MUL: begin
        // Product rule, second derivative carries the doubled cross term.
        rv = tdiv(f * g, 256'sd65536);
        r1 = tdiv(f1 * g + f * g1, 256'sd65536);
        r2 = tdiv(f2 * g + 2 * f1 * g1 + f * g2, 256'sd65536);
      end
      default: begin
        if (g == 0) begin
          o.status = soda_pkg::ST_DZ;
          return o;
        end
        d1 = f1 * g - f * g1;
        d2 = f2 * g - f * g2;
        gsq = g * g;
        gcb = gsq * g;
        rv = tdiv(f * 65536, g);
        r1 = tdiv(d1 * 65536, gsq);
        r2 = tdiv((d2 * g - 2 * d1 * g1) * 65536, gcb);
      end
    endcase
    o.res_value  = clamp32(rv, sat);
    o.res_first  = clamp32(r1, sat);
    o.res_second = clamp32(r2, sat);
    o.status     = sat ? soda_pkg::ST_SAT : soda_pkg::ST_OK;
    return o;
  endfunction

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4, 5: return $urandom;
      default: return $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
    endcase
  endfunction

  // Driver: present the next queued transaction at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        operands_t op;
        op = pending_ops.pop_front();
        req.valid    <= 1'b1;
        req.action   <= op.action;
        req.a_value  <= op.a_value;
        req.a_first  <= op.a_first;
        req.a_second <= op.a_second;
        req.b_value  <= op.b_value;
        req.b_first  <= op.b_first;
        req.b_second <= op.b_second;
      end else begin
        req.valid <= 1'b0;
      end
    end
    rsp.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    req_taken <= !rst && req.valid && req.ready;
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (req.valid && req.ready) begin
        expected_outcomes.push_back(dual_arith({req.action, req.a_value, req.a_first,
                                                req.a_second, req.b_value, req.b_first,
                                                req.b_second}));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_outcomes.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result transaction: expected none, got %h %h %h st%0d",
                     rsp.res_value, rsp.res_first, rsp.res_second, rsp.status);
        end else begin
          outcome_t want;
          want = expected_outcomes.pop_front();
          if (want.res_value !== rsp.res_value || want.res_first !== rsp.res_first ||
              want.res_second !== rsp.res_second || want.status !== rsp.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %h %h %h st%0d, got %h %h %h st%0d",
                       want.res_value, want.res_first, want.res_second, want.status,
                       rsp.res_value, rsp.res_first, rsp.res_second, rsp.status);
          end
        end
      end
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    operands_t op;
    req.valid = 1'b0; req.action = soda_pkg::ACT_ADD;
    req.a_value = 0; req.a_first = 0; req.a_second = 0;
    req.b_value = 0; req.b_first = 0; req.b_second = 0;
    rsp.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every action at the field extremes, divide by zero, scaling.
    for (int a = 0; a < 4; a++) begin
      pending_ops.push_back({a[1:0], {6{32'h7FFFFFFF}}});
      pending_ops.push_back({a[1:0], {6{32'h80000000}}});
      pending_ops.push_back({a[1:0], 32'h00018000, 32'hFFFF0000, 32'h00020000,
                             32'hFFFE8000, 32'h00004000, 32'h00010000});
    end
    pending_ops.push_back({soda_pkg::ACT_DIV, 32'h00010000, 32'h1, 32'h2, 32'h0, 32'h5,
                           32'h6});
    pending_ops.push_back({soda_pkg::ACT_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                           32'h00000001, 32'h7FFFFFFF, 32'h80000000});
    pending_ops.push_back({soda_pkg::ACT_DIV, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h0,
                           32'h0});
    pending_ops.push_back({soda_pkg::ACT_MUL, 32'h00030000, 32'h00010000, 32'h00020000,
                           32'h00028000, 32'h0, 32'h0});
    pending_ops.push_back({soda_pkg::ACT_MUL, 32'hFFFD0000, 32'h7FFFFFFF, 32'h80000000,
                           32'h00008000, 32'h0, 32'h0});

    for (int n = 0; n < N_RANDOM; n++) begin
      op.action   = 2'($urandom_range(0, 3));
      op.a_value  = pick_field(); op.a_first  = pick_field(); op.a_second = pick_field();
      op.b_value  = pick_field(); op.b_first  = pick_field(); op.b_second = pick_field();
      // Keep some multiplies as pure scalar scaling.
      if (op.action == soda_pkg::ACT_MUL && $urandom_range(0, 3) == 0) begin
        op.b_first = '0;
        op.b_second = '0;
      end
      pending_ops.push_back(op);
    end

    // Hold each idling pattern for a third of the stimulus.
    wait (pending_ops.size() < 2 * N_RANDOM / 3);
    src_idle_pct = 59; snk_idle_pct = 21;
    wait (pending_ops.size() < N_RANDOM / 3);
    src_idle_pct = 0; snk_idle_pct = 0;
    wait (pending_ops.size() == 0 && !req.valid);
    wait (expected_outcomes.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/soda_pkg.sv
design/soda_if.sv
design/soda_front.sv
design/soda_div.sv
design/soda_back.sv
design/second_order_dual_arithmetic_unit.sv
bench/tb_top.sv
